### src/crc_pkg.sv
// shared constants, types and helpers for the catalyzed reaction closure block
package crc_pkg;

  localparam int MAX_MOLECULES = 64;
  localparam int MAX_REACTIONS = 256;

  localparam int MOL_W   = $clog2(MAX_MOLECULES);
  localparam int CNT_W   = $clog2(MAX_MOLECULES + 1);
  localparam int ADDR_W  = $clog2(MAX_REACTIONS);
  localparam int FILL_W  = $clog2(MAX_REACTIONS + 1);
  localparam int CHUNK_W = 8;
  localparam int CHUNKS  = MAX_MOLECULES / CHUNK_W;
  localparam int SEL_W   = $clog2(CHUNKS);
  localparam int PC_W    = $clog2(CHUNK_W + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  // operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_PLAIN  = 2'd1;
  localparam logic [1:0] OP_CAT    = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOOD_MASK = 1'd1;

  localparam logic [CNT_W-1:0] MOL_COUNT_RST = CNT_W'(MAX_MOLECULES);

  typedef struct packed {
    logic             v;
    logic [MOL_W-1:0] idx;
  } slot_t;

  // record layout: cat, prod, sub_b, sub_a from msb to lsb
  typedef struct packed {
    slot_t cat;
    slot_t prod;
    slot_t sub_b;
    slot_t sub_a;
  } rec_t;

  typedef struct packed {
    logic              accept;
    logic              pop_en;
    logic [SEL_W-1:0]  pop_sel;
    logic              eval;
    logic              pass_clear;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              changed;
  } sts_t;

  function automatic logic [PC_W-1:0] pop_chunk(input logic [CHUNK_W-1:0] v);
    logic [PC_W-1:0] c;
    c = '0;
    for (int k = 0; k < CHUNK_W; k++) c = c + PC_W'(v[k]);
    return c;
  endfunction

endpackage

### src/crc_in_if.sv
// request channel carrying one reaction record or command
interface crc_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic                      sub_a_valid;
  logic [crc_pkg::MOL_W-1:0] sub_a;
  logic                      sub_b_valid;
  logic [crc_pkg::MOL_W-1:0] sub_b;
  logic                      prod_valid;
  logic [crc_pkg::MOL_W-1:0] prod;
  logic                      cat_valid;
  logic [crc_pkg::MOL_W-1:0] cat;

  modport source (
    output valid, op, sub_a_valid, sub_a, sub_b_valid, sub_b,
    output prod_valid, prod, cat_valid, cat,
    input  ready
  );
  modport sink (
    input  valid, op, sub_a_valid, sub_a, sub_b_valid, sub_b,
    input  prod_valid, prod, cat_valid, cat,
    output ready
  );
endinterface

### src/crc_out_if.sv
// result channel carrying the closure and table status
interface crc_out_if;
  logic                               valid;
  logic                               ready;
  logic [crc_pkg::MAX_MOLECULES-1:0]  closure_mask;
  logic [crc_pkg::CNT_W-1:0]          member_count;
  logic                               autocatalytic;
  logic                               table_full;
  logic [crc_pkg::FILL_W-1:0]         reaction_total;

  modport source (
    output valid, closure_mask, member_count, autocatalytic, table_full,
    output reaction_total,
    input  ready
  );
  modport sink (
    input  valid, closure_mask, member_count, autocatalytic, table_full,
    input  reaction_total,
    output ready
  );
endinterface

### src/crc_ctrl.sv
// sequencer: accept, food popcount, table sweeps, result handoff
module crc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  crc_pkg::sts_t       sts,
  output crc_pkg::cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [crc_pkg::SEL_W-1:0] LAST_CHUNK = crc_pkg::SEL_W'(crc_pkg::CHUNKS - 1);

  logic [1:0]                   state_r, state_nxt;
  logic [crc_pkg::SEL_W-1:0]    chunk_r, chunk_nxt;
  logic [crc_pkg::ADDR_W-1:0]   idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         last_entry;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign last_entry = ({1'b0, idx_r} + crc_pkg::FILL_W'(1)) == sts.fill;

  always_comb begin
    state_nxt = state_r;
    chunk_nxt = chunk_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          chunk_nxt  = '0;
          if (in_op == crc_pkg::OP_APPEND || in_op == crc_pkg::OP_CLEAR) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        cmd.pop_en  = 1'b1;
        cmd.pop_sel = chunk_r;
        chunk_nxt   = chunk_r + crc_pkg::SEL_W'(1);
        if (chunk_r == LAST_CHUNK) begin
          if (sts.fill == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt      = S_SWEEP;
            idx_nxt        = '0;
            cmd.rd_addr    = '0;
            cmd.pass_clear = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        cmd.eval = 1'b1;
        if (last_entry) begin
          if (sts.changed) begin
            idx_nxt        = '0;
            cmd.rd_addr    = '0;
            cmd.pass_clear = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt     = idx_r + crc_pkg::ADDR_W'(1);
          cmd.rd_addr = idx_r + crc_pkg::ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunk_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a sweep only runs over a non-empty table
  a_sweep_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> sts.fill != '0)
    else $error("sweep with empty table");

  // evaluated entry always lies below the fill level
  a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> ({1'b0, idx_r} < sts.fill))
    else $error("entry evaluated beyond fill");

  // a result appears only after the handoff state
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside handoff");
`endif

endmodule

### src/crc_dp.sv
// datapath: config, reaction table, present set, counts and result register
module crc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  crc_pkg::cmd_t                        cmd,
  output crc_pkg::sts_t                        sts,
  input  logic [1:0]                           in_op,
  input  crc_pkg::rec_t                        in_rec,
  input  logic                                 cfg_we,
  input  logic [crc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [crc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [crc_pkg::MAX_MOLECULES-1:0]    out_closure_mask,
  output logic [crc_pkg::CNT_W-1:0]            out_member_count,
  output logic                                 out_autocatalytic,
  output logic                                 out_table_full,
  output logic [crc_pkg::FILL_W-1:0]           out_reaction_total
);

  localparam logic [crc_pkg::FILL_W-1:0] FILL_MAX = crc_pkg::FILL_W'(crc_pkg::MAX_REACTIONS);

  crc_pkg::rec_t mem [crc_pkg::MAX_REACTIONS];

  logic [crc_pkg::CNT_W-1:0]          mc_r;
  logic [crc_pkg::MAX_MOLECULES-1:0]  food_r;
  logic [crc_pkg::FILL_W-1:0]         fill_r, fill_nxt;
  logic [1:0]                         op_r, op_nxt;
  logic                               full_r, full_nxt;
  logic [crc_pkg::MAX_MOLECULES-1:0]  present_r, present_nxt;
  logic [crc_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                               auto_r, auto_nxt;
  logic                               changed_r, changed_nxt;
  crc_pkg::rec_t                      rdata_r;

  logic [crc_pkg::MAX_MOLECULES-1:0]  avail;
  logic                               wr_en;
  logic                               catalyzed;
  logic                               cat_ok, a_ok, b_ok, prod_new, set_now;
  logic                               closure_op;
  logic [crc_pkg::CHUNK_W-1:0]        chunk;

  always_comb begin
    for (int i = 0; i < crc_pkg::MAX_MOLECULES; i++) begin
      avail[i] = crc_pkg::CNT_W'(i) < mc_r;
    end
  end

  assign wr_en = cmd.accept && (in_op == crc_pkg::OP_APPEND) && (fill_r < FILL_MAX);

  // firing test against the live present set
  assign catalyzed = (op_r == crc_pkg::OP_CAT);
  assign cat_ok    = !catalyzed || (rdata_r.cat.v && present_r[rdata_r.cat.idx]);
  assign a_ok      = !rdata_r.sub_a.v || present_r[rdata_r.sub_a.idx];
  assign b_ok      = !rdata_r.sub_b.v || present_r[rdata_r.sub_b.idx];
  assign prod_new  = rdata_r.prod.v && avail[rdata_r.prod.idx]
                     && !present_r[rdata_r.prod.idx];
  assign set_now   = cmd.eval && cat_ok && a_ok && b_ok && prod_new;

  assign chunk      = present_r[{cmd.pop_sel, 3'b000} +: crc_pkg::CHUNK_W];
  assign closure_op = (op_r == crc_pkg::OP_PLAIN) || (op_r == crc_pkg::OP_CAT);

  assign sts.fill    = fill_r;
  assign sts.changed = changed_r || set_now;

  always_comb begin
    fill_nxt    = fill_r;
    op_nxt      = op_r;
    full_nxt    = full_r;
    present_nxt = present_r;
    cnt_nxt     = cnt_r;
    auto_nxt    = auto_r;
    changed_nxt = cmd.pass_clear ? 1'b0 : (changed_r || set_now);
    if (cmd.accept) begin
      op_nxt      = in_op;
      full_nxt    = (in_op == crc_pkg::OP_APPEND) && (fill_r == FILL_MAX);
      present_nxt = food_r & avail;
      cnt_nxt     = '0;
      auto_nxt    = 1'b0;
      if (wr_en) begin
        fill_nxt = fill_r + crc_pkg::FILL_W'(1);
      end else if (in_op == crc_pkg::OP_CLEAR) begin
        fill_nxt = '0;
      end
    end
    if (cmd.pop_en) begin
      cnt_nxt = cnt_r + crc_pkg::CNT_W'(crc_pkg::pop_chunk(chunk));
    end
    if (set_now) begin
      present_nxt[rdata_r.prod.idx] = 1'b1;
      cnt_nxt  = cnt_r + crc_pkg::CNT_W'(1);
      auto_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[crc_pkg::ADDR_W-1:0]] <= in_rec;
    end
    rdata_r <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r      <= crc_pkg::MOL_COUNT_RST;
      food_r    <= '0;
      fill_r    <= '0;
      cnt_r     <= '0;
      auto_r    <= 1'b0;
      changed_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == crc_pkg::REG_MOL_COUNT) begin
        mc_r <= cfg_data[crc_pkg::CNT_W-1:0];
      end
      if (cfg_we && cfg_index == crc_pkg::REG_FOOD_MASK) begin
        food_r <= cfg_data[crc_pkg::MAX_MOLECULES-1:0];
      end
      fill_r    <= fill_nxt;
      cnt_r     <= cnt_nxt;
      auto_r    <= auto_nxt;
      changed_r <= changed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    full_r    <= full_nxt;
    present_r <= present_nxt;
    if (cmd.out_load) begin
      out_closure_mask   <= closure_op ? present_r : '0;
      out_member_count   <= closure_op ? cnt_r : '0;
      out_autocatalytic  <= closure_op && auto_r;
      out_table_full     <= full_r;
      out_reaction_total <= fill_r;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill above table depth");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= crc_pkg::CNT_W'(crc_pkg::MAX_MOLECULES))
    else $error("member count above molecule limit");

  // any fired product means at least one member
  a_auto_count: assert property (@(posedge clk) disable iff (!rst_n)
    auto_r |-> cnt_r != '0)
    else $error("autocatalytic with empty count");
`endif

endmodule

### src/catalyzed_reaction_closure.sv
// top level of the catalyzed reaction closure block
//
//  channel  direction  payload                                          handshake
//  in_ch    sink       op, sub_a/sub_b/prod/cat with valid flags        valid/ready
//  out_ch   source     closure_mask, member_count, autocatalytic,       valid/ready
//                      table_full, reaction_total
//  cfg_*    write      cfg_index 0 molecule_count, 1 food_mask          cfg_we
//
// append and clear: accept, then handoff to the result register
// a closure: food popcount (one byte a cycle), then, if the table is not empty,
//   full sweeps of the table at one entry per cycle
//   through the single table read port until a pass adds nothing (at most 65)
// one request at a time; the next is taken while the previous result waits
// rst_n is synchronous: empties the table, molecule_count 64, food_mask 0
// table contents are not cleared; entries past the fill level are never read
module catalyzed_reaction_closure (
  input  logic                                clk,
  input  logic                                rst_n,
  crc_in_if.sink                              in_ch,
  crc_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [crc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  crc_pkg::cmd_t cmd;
  crc_pkg::sts_t sts;
  crc_pkg::rec_t in_rec;

  // pack the request fields into the stored record layout
  assign in_rec.sub_a.v   = in_ch.sub_a_valid;
  assign in_rec.sub_a.idx = in_ch.sub_a;
  assign in_rec.sub_b.v   = in_ch.sub_b_valid;
  assign in_rec.sub_b.idx = in_ch.sub_b;
  assign in_rec.prod.v    = in_ch.prod_valid;
  assign in_rec.prod.idx  = in_ch.prod;
  assign in_rec.cat.v     = in_ch.cat_valid;
  assign in_rec.cat.idx   = in_ch.cat;

  // sequencer
  crc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, present set and result register
  crc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_ch.op),
    .in_rec             (in_rec),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_closure_mask   (out_ch.closure_mask),
    .out_member_count   (out_ch.member_count),
    .out_autocatalytic  (out_ch.autocatalytic),
    .out_table_full     (out_ch.table_full),
    .out_reaction_total (out_ch.reaction_total)
  );

endmodule
